FILE: rtl/core/pra_pkg.sv
// pra_pkg: request and status codes and fixed field widths of the page allocator
// no dependencies
package pra_pkg;

    localparam int PAGE_IDX_W = 12;
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int REF_OUT_W  = 8;
    localparam int FREE_W     = 13;
    localparam int CFG_DATA_W = 13;

    typedef logic [REQ_W-1:0]    t_req;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_req REQ_ALLOC = 3'd0;
    localparam t_req REQ_FREE  = 3'd1;
    localparam t_req REQ_INC   = 3'd2;
    localparam t_req REQ_DEC   = 3'd3;
    localparam t_req REQ_QUERY = 3'd4;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_EMPTY  = 2'd1;
    localparam t_status ST_BOUNDS = 2'd2;
    localparam t_status ST_FULL   = 2'd3;

    localparam logic CFG_LOWEST_PAGE = 1'b0;
    localparam logic CFG_PAGE_LIMIT  = 1'b1;

endpackage

FILE: rtl/core/refcounted_page_allocator.sv
// refcounted_page_allocator: top level, request sequencer, free count and result register
// depends on pra_pkg, pra_stack_mem, pra_ref_mem
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-----------------------------------------------
//  request  | i_in_valid  / o_in_stall      | i_req_type, i_page_index
//  result   | o_out_valid / i_out_stall     | o_status, o_given_page, o_ref_value, o_free_total
//  config   | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// a request first reads the count and stack memories, then modifies and writes back;
// the next request is taken in the cycle after the write-back
// the result stage holds one beat; a stalled result holds the write-back until it drains
// after reset a sweep clears all NUM_PAGES entries of the count memory with requests stalled
// configuration writes are taken in every cycle
module refcounted_page_allocator #(
    parameter int NUM_PAGES = 4096,
    parameter int REF_BITS  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pra_pkg::t_req                    i_req_type,
    input  logic [pra_pkg::PAGE_IDX_W-1:0]   i_page_index,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pra_pkg::t_status                 o_status,
    output logic [pra_pkg::PAGE_IDX_W-1:0]   o_given_page,
    output logic [pra_pkg::REF_OUT_W-1:0]    o_ref_value,
    output logic [pra_pkg::FREE_W-1:0]       o_free_total,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [pra_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int ADDR_W  = $clog2(NUM_PAGES);
    localparam int DEPTH_W = ADDR_W + 1;
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;
    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

    logic                                r_state;
    logic                                n_state;
    pra_pkg::t_req                       r_req;
    logic [pra_pkg::PAGE_IDX_W-1:0]      r_page;
    logic [DEPTH_W-1:0]                  r_depth;
    logic [DEPTH_W-1:0]                  n_depth;
    logic [pra_pkg::PAGE_IDX_W-1:0]      r_lowest;
    logic [pra_pkg::CFG_DATA_W-1:0]      r_limit;

    logic                                r_out_valid;
    pra_pkg::t_status                    r_status;
    logic [pra_pkg::PAGE_IDX_W-1:0]      r_given;
    logic [pra_pkg::REF_OUT_W-1:0]       r_ref;
    logic [pra_pkg::FREE_W-1:0]          r_free;

    logic                                clear_done;
    logic                                accept;
    logic                                fire;
    logic [REF_BITS-1:0]                 ref_rd;
    logic [ADDR_W-1:0]                   stack_rd;
    logic [DEPTH_W-1:0]                  depth_dec;

    logic                                ref_we;
    logic [ADDR_W-1:0]                   ref_wa;
    logic [REF_BITS-1:0]                 ref_wd;
    logic                                stack_we;
    pra_pkg::t_status                    n_status;
    logic [ADDR_W-1:0]                   n_given;
    logic [REF_BITS-1:0]                 n_ref;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || !clear_done;
    assign fire       = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign depth_dec  = r_depth - 1'b1;
    assign o_cfg_ready = 1'b1;

    pra_stack_mem #(
        .NUM_PAGES (NUM_PAGES)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (depth_dec[ADDR_W-1:0]),
        .o_rd_data (stack_rd),
        .i_wr_en   (stack_we),
        .i_wr_addr (r_depth[ADDR_W-1:0]),
        .i_wr_data (ADDR_W'(r_page))
    );

    pra_ref_mem #(
        .NUM_PAGES (NUM_PAGES),
        .REF_BITS  (REF_BITS)
    ) u_ref (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (accept),
        .i_rd_addr    (ADDR_W'(i_page_index)),
        .o_rd_data    (ref_rd),
        .i_wr_en      (ref_we),
        .i_wr_addr    (ref_wa),
        .i_wr_data    (ref_wd),
        .o_clear_done (clear_done)
    );

    always_comb begin
        logic in_table;
        logic in_bounds;
        in_table  = 32'(r_page) < NUM_PAGES;
        in_bounds = in_table && (r_page >= r_lowest)
                    && (pra_pkg::CFG_DATA_W'(r_page) < r_limit);
        n_status = pra_pkg::ST_OK;
        n_given  = '0;
        n_ref    = '0;
        n_depth  = r_depth;
        ref_we   = 1'b0;
        ref_wa   = ADDR_W'(r_page);
        ref_wd   = ref_rd;
        stack_we = 1'b0;
        case (r_req)
            pra_pkg::REQ_ALLOC: begin
                if (r_depth == '0) begin
                    n_status = pra_pkg::ST_EMPTY;
                end else begin
                    n_depth = depth_dec;
                    n_given = stack_rd;
                    n_ref   = REF_ONE;
                    ref_we  = 1'b1;
                    ref_wa  = stack_rd;
                    ref_wd  = REF_ONE;
                end
            end
            pra_pkg::REQ_FREE: begin
                if (!in_bounds) begin
                    n_status = pra_pkg::ST_BOUNDS;
                    n_ref    = in_table ? ref_rd : '0;
                end else if (ref_rd <= REF_ONE) begin
                    n_ref = ref_rd;
                    if (32'(r_depth) >= NUM_PAGES) begin
                        n_status = pra_pkg::ST_FULL;
                    end else begin
                        stack_we = 1'b1;
                        n_depth  = r_depth + 1'b1;
                    end
                end else begin
                    ref_we = 1'b1;
                    ref_wd = ref_rd - 1'b1;
                    n_ref  = ref_rd - 1'b1;
                end
            end
            pra_pkg::REQ_INC, pra_pkg::REQ_DEC, pra_pkg::REQ_QUERY: begin
                if (!in_table) begin
                    n_status = pra_pkg::ST_BOUNDS;
                end else begin
                    n_ref = ref_rd;
                    if (r_req == pra_pkg::REQ_INC && ref_rd != REF_MAX) begin
                        n_ref = ref_rd + 1'b1;
                    end else if (r_req == pra_pkg::REQ_DEC && ref_rd != '0) begin
                        n_ref = ref_rd - 1'b1;
                    end
                    ref_we = (r_req != pra_pkg::REQ_QUERY);
                    ref_wd = n_ref;
                end
            end
            default: begin
                n_status = pra_pkg::ST_OK;
            end
        endcase
        ref_we   = ref_we && fire;
        stack_we = stack_we && fire;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_EXEC;
            S_EXEC:  if (fire)   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
            r_lowest    <= '0;
            r_limit     <= pra_pkg::CFG_DATA_W'(4096);
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_depth     <= n_depth;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    pra_pkg::CFG_LOWEST_PAGE: r_lowest <= i_cfg_data[pra_pkg::PAGE_IDX_W-1:0];
                    pra_pkg::CFG_PAGE_LIMIT:  r_limit  <= i_cfg_data;
                    default: r_limit <= r_limit;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req_type;
            r_page <= i_page_index;
        end
        if (fire) begin
            r_status <= n_status;
            r_given  <= pra_pkg::PAGE_IDX_W'(n_given);
            r_ref    <= pra_pkg::REF_OUT_W'(n_ref);
            r_free   <= pra_pkg::FREE_W'(n_depth);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_given_page = r_given;
    assign o_ref_value  = r_ref;
    assign o_free_total = r_free;

endmodule

FILE: rtl/core/pra_stack_mem.sv
// pra_stack_mem: free page stack storage, one write and one registered read port
// no package dependencies
module pra_stack_mem #(
    parameter int NUM_PAGES = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(NUM_PAGES)-1:0] i_rd_addr,
    output logic [$clog2(NUM_PAGES)-1:0] o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(NUM_PAGES)-1:0] i_wr_addr,
    input  logic [$clog2(NUM_PAGES)-1:0] i_wr_data
);

    localparam int ADDR_W = $clog2(NUM_PAGES);

    logic [ADDR_W-1:0] r_mem [NUM_PAGES];
    logic [ADDR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/pra_ref_mem.sv
// pra_ref_mem: per-page reference count storage with a clearing sweep after reset
// no package dependencies
module pra_ref_mem #(
    parameter int NUM_PAGES = 4096,
    parameter int REF_BITS  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(NUM_PAGES)-1:0] i_rd_addr,
    output logic [REF_BITS-1:0]          o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(NUM_PAGES)-1:0] i_wr_addr,
    input  logic [REF_BITS-1:0]          i_wr_data,
    output logic                         o_clear_done
);

    localparam int ADDR_W = $clog2(NUM_PAGES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_PAGES - 1);

    logic [REF_BITS-1:0] r_mem [NUM_PAGES];
    logic [REF_BITS-1:0] r_rd_data;
    logic                r_clearing;
    logic [ADDR_W-1:0]   r_clr_addr;

    logic                we;
    logic [ADDR_W-1:0]   wa;
    logic [REF_BITS-1:0] wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_comb begin
        we = i_wr_en;
        wa = i_wr_addr;
        wd = i_wr_data;
        if (r_clearing) begin
            we = 1'b1;
            wa = r_clr_addr;
            wd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_clear_done = !r_clearing;

endmodule

FILE: dv/refcounted_page_allocator_checker.sv
// refcounted_page_allocator_checker: watches the request, result and config channels,
// predicts every result beat and compares it field by field
// depends on pra_pkg
module refcounted_page_allocator_checker #(
    parameter int NUM_PAGES = 4096,
    parameter int REF_BITS  = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  pra_pkg::t_req                  i_req_type,
    input  logic [pra_pkg::PAGE_IDX_W-1:0] i_page_index,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  pra_pkg::t_status               i_status,
    input  logic [pra_pkg::PAGE_IDX_W-1:0] i_given_page,
    input  logic [pra_pkg::REF_OUT_W-1:0]  i_ref_value,
    input  logic [pra_pkg::FREE_W-1:0]     i_free_total,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [pra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_mismatch_count,
    output int                             o_results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        pra_pkg::t_status               status;
        logic [pra_pkg::PAGE_IDX_W-1:0] given_page;
        logic [pra_pkg::REF_OUT_W-1:0]  ref_value;
        logic [pra_pkg::FREE_W-1:0]     free_total;
    } t_page_result;

    logic [REF_BITS-1:0]            ref_count [NUM_PAGES];
    logic [pra_pkg::PAGE_IDX_W-1:0] stack_model [NUM_PAGES];
    logic [pra_pkg::FREE_W-1:0]     free_depth;
    logic [pra_pkg::PAGE_IDX_W-1:0] lowest_page;
    logic [pra_pkg::CFG_DATA_W-1:0] page_limit;
    t_page_result                   owed_results [$];
    t_page_result                   want;
    t_page_result                   got;
    int                             mismatches = 0;
    int                             result_beats = 0;

    assign o_mismatch_count = mismatches;

    task automatic report_mismatch(string what, int got_val, int want_val);
        mismatches++;
        $display("[%0t] mismatch on result beat %0d: %s got %0d want %0d",
                 $realtime, result_beats, what, got_val, want_val);
    endtask

    function automatic t_page_result apply_request(pra_pkg::t_req req,
                                                   logic [pra_pkg::PAGE_IDX_W-1:0] pg);
        t_page_result        res;
        logic [REF_BITS-1:0] cnt;
        logic                in_table;
        res      = '0;
        cnt      = '0;
        in_table = int'(pg) < NUM_PAGES;
        case (req)
            pra_pkg::REQ_ALLOC: begin
                if (free_depth == 0) begin
                    res.status = pra_pkg::ST_EMPTY;
                end else begin
                    free_depth--;
                    res.given_page = stack_model[free_depth];
                    ref_count[res.given_page] = 1;
                    cnt = 1;
                end
            end
            pra_pkg::REQ_FREE: begin
                if (!in_table || pg < lowest_page || pg >= page_limit) begin
                    res.status = pra_pkg::ST_BOUNDS;
                    if (in_table)
                        cnt = ref_count[pg];
                end else if (ref_count[pg] <= 1) begin
                    if (free_depth >= NUM_PAGES) begin
                        res.status = pra_pkg::ST_FULL;
                    end else begin
                        stack_model[free_depth] = pg;
                        free_depth++;
                    end
                    cnt = ref_count[pg];
                end else begin
                    ref_count[pg]--;
                    cnt = ref_count[pg];
                end
            end
            pra_pkg::REQ_INC, pra_pkg::REQ_DEC, pra_pkg::REQ_QUERY: begin
                if (!in_table) begin
                    res.status = pra_pkg::ST_BOUNDS;
                end else begin
                    if (req == pra_pkg::REQ_INC && ref_count[pg] != {REF_BITS{1'b1}})
                        ref_count[pg]++;
                    else if (req == pra_pkg::REQ_DEC && ref_count[pg] != 0)
                        ref_count[pg]--;
                    cnt = ref_count[pg];
                end
            end
            default: begin
            end
        endcase
        res.ref_value  = pra_pkg::REF_OUT_W'(cnt);
        res.free_total = free_depth;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (ref_count[i]) ref_count[i] = '0;
            free_depth  = '0;
            lowest_page = '0;
            page_limit  = pra_pkg::CFG_DATA_W'(4096);
            owed_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == pra_pkg::CFG_LOWEST_PAGE)
                    lowest_page = i_cfg_data[pra_pkg::PAGE_IDX_W-1:0];
                else
                    page_limit = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall)
                owed_results.push_back(apply_request(i_req_type, i_page_index));
            if (i_out_valid && !i_out_stall) begin
                got = '{i_status, i_given_page, i_ref_value, i_free_total};
                if (owed_results.size() == 0) begin
                    report_mismatch("beat with nothing owed, status", got.status, 0);
                end else begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.given_page !== want.given_page)
                        report_mismatch("given_page", got.given_page, want.given_page);
                    if (got.ref_value !== want.ref_value)
                        report_mismatch("ref_value", got.ref_value, want.ref_value);
                    if (got.free_total !== want.free_total)
                        report_mismatch("free_total", got.free_total, want.free_total);
                end
                result_beats++;
            end
        end
        o_results_owed <= owed_results.size();
    end

endmodule

FILE: dv/refcounted_page_allocator_tb.sv
// refcounted_page_allocator_tb: stimulus, idling and verdict for the page allocator
// depends on pra_pkg, refcounted_page_allocator and refcounted_page_allocator_checker
module refcounted_page_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 200;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    pra_pkg::t_req                  i_req_type = pra_pkg::REQ_QUERY;
    logic [pra_pkg::PAGE_IDX_W-1:0] i_page_index = '0;
    logic                           i_out_stall = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           i_cfg_index = pra_pkg::CFG_LOWEST_PAGE;
    logic [pra_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    pra_pkg::t_status               o_status;
    logic [pra_pkg::PAGE_IDX_W-1:0] o_given_page;
    logic [pra_pkg::REF_OUT_W-1:0]  o_ref_value;
    logic [pra_pkg::FREE_W-1:0]     o_free_total;
    logic                           o_cfg_ready;
    int                             mismatch_count;
    int                             results_owed;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_id = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int requests_sent = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    refcounted_page_allocator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_page_index (i_page_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_given_page (o_given_page),
        .o_ref_value  (o_ref_value),
        .o_free_total (o_free_total),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    refcounted_page_allocator_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_page_index     (i_page_index),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_given_page     (o_given_page),
        .i_ref_value      (o_ref_value),
        .i_free_total     (o_free_total),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_results_owed   (results_owed)
    );

    // result side: random stall, or a long hold-off when one is asked for
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_seen != hold_id) begin
            hold_seen   <= hold_id;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= $urandom_range(0, 99) < stall_pct;
        end
    end

    task automatic send_req(pra_pkg::t_req req, logic [pra_pkg::PAGE_IDX_W-1:0] page);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_page_index <= page;
        do @(posedge i_clk); while (o_in_stall);
        requests_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [pra_pkg::CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct    <= recv_pct;
    endtask

    task automatic random_requests(int n, logic [pra_pkg::PAGE_IDX_W-1:0] pool_base);
        int                             pick;
        pra_pkg::t_req                  req;
        logic [pra_pkg::PAGE_IDX_W-1:0] pg;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                req = pra_pkg::REQ_ALLOC;
            else if (pick < 50)
                req = pra_pkg::REQ_FREE;
            else if (pick < 65)
                req = pra_pkg::REQ_INC;
            else if (pick < 80)
                req = pra_pkg::REQ_DEC;
            else if (pick < 95)
                req = pra_pkg::REQ_QUERY;
            else
                req = pra_pkg::t_req'($urandom_range(int'(pra_pkg::REQ_QUERY) + 1,
                                                     (1 << pra_pkg::REQ_W) - 1));
            // mostly pages near the bounds, some anywhere
            if ($urandom_range(0, 9) < 8)
                pg = pool_base + pra_pkg::PAGE_IDX_W'($urandom_range(0, 31));
            else
                pg = pra_pkg::PAGE_IDX_W'($urandom);
            send_req(req, pg);
        end
    endtask

    task automatic run_phase(logic [pra_pkg::CFG_DATA_W-1:0] lowest,
                             logic [pra_pkg::CFG_DATA_W-1:0] limit,
                             int send_pct, int recv_pct,
                             logic [pra_pkg::PAGE_IDX_W-1:0] pool_base);
        write_reg(pra_pkg::CFG_LOWEST_PAGE, lowest);
        write_reg(pra_pkg::CFG_PAGE_LIMIT, limit);
        set_idling(send_pct, recv_pct);
        random_requests(60, pool_base);
        hold_id <= hold_id + 1;
        random_requests(60, pool_base);
        wait_idle();
        random_requests(60, pool_base);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners: empty stack, ends of the page range, double free, unknown requests
        send_req(pra_pkg::REQ_ALLOC, 12'hFFF);
        send_req(pra_pkg::REQ_QUERY, 12'h000);
        send_req(pra_pkg::REQ_QUERY, 12'hFFF);
        send_req(pra_pkg::REQ_INC, 12'hFFF);
        send_req(pra_pkg::REQ_DEC, 12'h000);
        send_req(pra_pkg::REQ_DEC, 12'hFFF);
        send_req(pra_pkg::REQ_FREE, 12'h000);
        send_req(pra_pkg::REQ_FREE, 12'h000);
        send_req(pra_pkg::REQ_ALLOC, 12'h000);
        send_req(pra_pkg::REQ_ALLOC, 12'hFFF);
        send_req(pra_pkg::REQ_ALLOC, 12'h000);
        send_req(pra_pkg::REQ_INC, 12'h007);
        send_req(pra_pkg::REQ_INC, 12'h007);
        send_req(pra_pkg::REQ_FREE, 12'h007);
        send_req(pra_pkg::REQ_FREE, 12'h007);
        send_req(pra_pkg::REQ_FREE, 12'hFFF);
        for (int u = int'(pra_pkg::REQ_QUERY) + 1; u < (1 << pra_pkg::REQ_W); u++)
            send_req(pra_pkg::t_req'(u), 12'hAAA);

        write_reg(pra_pkg::CFG_LOWEST_PAGE, 13'd16);
        write_reg(pra_pkg::CFG_PAGE_LIMIT, 13'd32);
        send_req(pra_pkg::REQ_FREE, 12'd15);
        send_req(pra_pkg::REQ_FREE, 12'd32);
        send_req(pra_pkg::REQ_FREE, 12'd16);
        send_req(pra_pkg::REQ_FREE, 12'd31);
        send_req(pra_pkg::REQ_INC, 12'd15);
        send_req(pra_pkg::REQ_ALLOC, 12'h555);
        write_reg(pra_pkg::CFG_LOWEST_PAGE, 13'h1000);
        write_reg(pra_pkg::CFG_PAGE_LIMIT, 13'd4096);

        // count saturation at the upper end, then one decrement from the top
        set_idling(0, 66);
        for (int k = 0; k < 257; k++)
            send_req(pra_pkg::REQ_INC, 12'h555);
        send_req(pra_pkg::REQ_QUERY, 12'h555);
        send_req(pra_pkg::REQ_DEC, 12'h555);

        // push a run of pages and repeated frees, then drain past empty
        set_idling(0, 0);
        for (int p = 0; p < 64; p++)
            send_req(pra_pkg::REQ_FREE, pra_pkg::PAGE_IDX_W'(p));
        for (int k = 0; k < 16; k++)
            send_req(pra_pkg::REQ_FREE, 12'h001);
        set_idling(35, 35);
        for (int k = 0; k < 90; k++)
            send_req(pra_pkg::REQ_ALLOC, pra_pkg::PAGE_IDX_W'($urandom));

        run_phase(13'h0000, 13'd4096, 0, 0, 12'h000);
        run_phase(13'h1048, 13'h0058, 66, 0, 12'h040);
        run_phase(13'h1FFF, 13'd4096, 0, 66, 12'hFE0);
        run_phase(13'h0000, 13'd1, 35, 35, 12'h000);

        wait_idle();
        repeat (16) @(posedge i_clk);
        $display("covered %0d request beats: corner requests, count saturation, stack pushes",
                 requests_sent);
        $display("and drain past empty, four random phases over bound settings, idling mixes");
        if (mismatch_count == 0 && results_owed == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
